// ----- sv/cc32_pkg.sv -----
package cc32_pkg;

    localparam int CHUNK_BYTES  = 512;
    localparam int PACKET_BYTES = 65536;

    localparam int CHUNK_W = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int PKT_W   = $clog2(PACKET_BYTES);

    localparam logic [CHUNK_W-1:0] CHUNK_LAST  = CHUNK_W'(CHUNK_BYTES - 1);
    localparam logic [PKT_W-1:0]   PACKET_LAST = PKT_W'(PACKET_BYTES - 1);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic [31:0] packet_number;
        logic        ends_block;
        logic        ends_packet;
        logic [31:0] chunk_crc;
    } t_result;

endpackage

// ----- sv/cc32_crc_byte.sv -----
module cc32_crc_byte
    import cc32_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] v_crc;
        v_crc = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            v_crc = (v_crc >> 1) ^ (CRC_POLY & {32{v_crc[0]}});
        end
        o_crc = v_crc;
    end

endmodule

// ----- sv/cc32_chunk_ctl.sv -----
module cc32_chunk_ctl
    import cc32_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_fire,
    output t_result     o_res
);

    logic [31:0]        r_crc;
    logic [CHUNK_W-1:0] r_chunk_bytes;
    logic [PKT_W-1:0]   r_pkt_bytes;
    logic [31:0]        r_pkt_seq;

    logic [31:0]        n_crc;
    logic               chunk_full;
    logic               pkt_end;

    cc32_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (n_crc)
    );

    assign chunk_full = (r_chunk_bytes == CHUNK_LAST);
    assign pkt_end    = (r_pkt_bytes == PACKET_LAST);
    assign o_fire     = chunk_full || pkt_end || i_last;

    assign o_res.chunk_crc     = ~n_crc;
    assign o_res.ends_packet   = pkt_end || i_last;
    assign o_res.ends_block    = i_last;
    assign o_res.packet_number = r_pkt_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc         <= CRC_INIT;
            r_chunk_bytes <= '0;
            r_pkt_bytes   <= '0;
            r_pkt_seq     <= '0;
        end else if (i_step) begin
            priority if (i_last) begin
                r_crc         <= CRC_INIT;
                r_chunk_bytes <= '0;
                r_pkt_bytes   <= '0;
                r_pkt_seq     <= '0;
            end else if (pkt_end) begin
                r_crc         <= CRC_INIT;
                r_chunk_bytes <= '0;
                r_pkt_bytes   <= '0;
                r_pkt_seq     <= r_pkt_seq + 32'd1;
            end else if (chunk_full) begin
                r_crc         <= CRC_INIT;
                r_chunk_bytes <= '0;
                r_pkt_bytes   <= r_pkt_bytes + PKT_W'(1);
            end else begin
                r_crc         <= n_crc;
                r_chunk_bytes <= r_chunk_bytes + CHUNK_W'(1);
                r_pkt_bytes   <= r_pkt_bytes + PKT_W'(1);
            end
        end
    end

endmodule

// ----- sv/chunked_crc32_checksum_gen_top.sv -----
// channel  dir  tdata                          tuser        tlast
// s        in   [7:0] data_byte                -            block_end
// m        out  [31:0] chunk_crc,              ends_packet  ends_block
//               [63:32] packet_number
//
// one byte per clock sustained while the result side does not stall; a request passes an
// input register, then a result register that is loaded together with the crc and chunk counters
// the single-byte crc step between input register and counters sets the clock path
// synchronous active-low reset clears counters, crc and both valid flags
// a stalled result holds the output register; the input register still
// advances when its byte finishes no chunk
module chunked_crc32_checksum_gen_top
    import cc32_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // data_byte
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // chunk_crc, packet_number
    output logic                  o_m_tuser,   // ends_packet
    output logic                  o_m_tlast
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;

    logic        fire;
    logic        step;
    t_result     res;

    assign step       = r_in_valid && (!fire || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || step;

    cc32_chunk_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_fire  (fire),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata[7:0];
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && fire) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.packet_number, r_out.chunk_crc};
    assign o_m_tuser  = r_out.ends_packet;
    assign o_m_tlast  = r_out.ends_block;

endmodule

// ----- sv/cc32_checker.sv -----
module cc32_checker
    import cc32_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  o_s_tready,
    input  logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  o_m_tuser,
    input  logic                  o_m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // block end always closes the packet
    a_last_ends_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser)
        else $error("block end without packet end");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // empty input register takes a request right after reset
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("not ready after reset");

    // with no request right after reset, nothing can reach the output
    a_no_phantom: assert property (@(posedge i_clk)
        !i_rst_n ##1 !i_s_tvalid |=> !o_m_tvalid)
        else $error("result without request");

endmodule

bind chunked_crc32_checksum_gen_top cc32_checker u_cc32_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ----- sim/testbench.sv -----
module testbench;
    import cc32_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 16;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;   // data_byte
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;        // chunk_crc, packet_number
    logic                  o_m_tuser;        // ends_packet
    logic                  o_m_tlast;        // ends_block

    chunked_crc32_checksum_gen_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // predictor state
    logic [31:0] crc_acc;
    int unsigned chunk_fill;
    int unsigned packet_chunks;
    logic [31:0] packet_seq_num;

    t_result pending_chunks[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int unsigned cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned chunks_seen = 0;
    int unsigned packet_ends = 0;
    int unsigned block_ends = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB8_8320) : (r >> 1);
        end
        return r;
    endfunction

    task automatic clear_crc_state();
        crc_acc = 32'hFFFF_FFFF;
        chunk_fill = 0;
        packet_chunks = 0;
        packet_seq_num = '0;
    endtask

    task automatic predict_chunk_crc(input logic [7:0] b, input logic last);
        int unsigned in_chunk;
        longint unsigned in_packet;
        bit pkt_end;
        t_result r;
        crc_acc = crc32_byte(crc_acc, b);
        in_chunk = chunk_fill + 1;
        in_packet = longint'(packet_chunks) * CHUNK_BYTES + in_chunk;
        pkt_end = (in_packet >= PACKET_BYTES);
        if (in_chunk >= CHUNK_BYTES || pkt_end || last) begin
            r.chunk_crc = ~crc_acc;
            r.ends_packet = pkt_end || last;
            r.ends_block = last;
            r.packet_number = packet_seq_num;
            pending_chunks.push_back(r);
            crc_acc = 32'hFFFF_FFFF;
            chunk_fill = 0;
            if (last) begin
                packet_chunks = 0;
                packet_seq_num = '0;
            end else if (pkt_end) begin
                packet_chunks = 0;
                packet_seq_num = packet_seq_num + 32'd1;
            end else begin
                packet_chunks = packet_chunks + 1;
            end
        end else begin
            chunk_fill = in_chunk;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tlast <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_chunk_crc(b, last);
        bytes_sent++;
    endtask

    task automatic send_block(input int unsigned len);
        for (int unsigned n = 1; n <= len; n++) begin
            send_byte(8'($urandom), n == len);
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.chunk_crc = o_m_tdata[31:0];
            got.packet_number = o_m_tdata[63:32];
            got.ends_packet = o_m_tuser;
            got.ends_block = o_m_tlast;
            chunks_seen++;
            if (got.ends_packet) packet_ends++;
            if (got.ends_block) block_ends++;
            if (pending_chunks.size() == 0) begin
                $error("unexpected result crc %h packet %0d", got.chunk_crc, got.packet_number);
                errors++;
            end else begin
                want = pending_chunks.pop_front();
                if (got.chunk_crc !== want.chunk_crc) begin
                    $error("chunk_crc expected %h got %h", want.chunk_crc, got.chunk_crc);
                    errors++;
                end
                if (got.ends_packet !== want.ends_packet) begin
                    $error("ends_packet expected %b got %b", want.ends_packet, got.ends_packet);
                    errors++;
                end
                if (got.ends_block !== want.ends_block) begin
                    $error("ends_block expected %b got %b", want.ends_block, got.ends_block);
                    errors++;
                end
                if (got.packet_number !== want.packet_number) begin
                    $error("packet_number expected %0d got %0d",
                           want.packet_number, got.packet_number);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_chunks.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // single-byte blocks, the check string and a short block of extremes
    task automatic test_short_blocks();
        string check_str;
        check_str = "123456789";
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b1);
        for (int i = 0; i < check_str.len(); i++) begin
            send_byte(check_str[i], i == check_str.len() - 1);
        end
        for (int i = 0; i < 8; i++) begin
            send_byte((i % 2) ? 8'hFF : 8'h00, i == 7);
        end
    endtask

    // full chunk inside a block, then a one-byte chunk closing the block
    task automatic test_chunk_fill();
        send_block(CHUNK_BYTES + 1);
    endtask

    task automatic test_random_blocks(input int unsigned n_bytes);
        int unsigned start;
        int unsigned len;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            send_block(len);
        end
    endtask

    initial begin
        clear_crc_state();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 13;
        recv_idle_pct = 71;
        test_short_blocks();
        test_chunk_fill();
        test_random_blocks(25);

        send_idle_pct = 71;
        recv_idle_pct = 13;
        test_random_blocks(25);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_blocks(25);

        i_s_tvalid <= 1'b0;
        while (pending_chunks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes; checked %0d chunk results", bytes_sent, chunks_seen);
        $display("%0d packet ends and %0d block ends seen", packet_ends, block_ends);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
